>>> design/ifsf_pkg.sv
// ----------------------------------------------------------------------------
// ifsf_pkg
// Shared types and constants for the fern point generator: field widths,
// map thresholds, register indexes, reset values and the command and status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package ifsf_pkg;

    localparam int FRAC_BITS_DEF = 15;

    localparam int RAND_W     = 31;
    localparam int DATA_W     = 32;
    localparam int COEF_W     = 17;
    localparam int OFF_W      = 18;
    localparam int SCALE_W    = 21;
    localparam int CFG_DATA_W = 21;
    localparam int CFG_IDX_W  = 3;

    localparam logic [RAND_W-1:0] STEM_LIMIT = 31'd21474835;
    localparam logic [RAND_W-1:0] MAIN_LIMIT = 31'd1846835936;
    localparam logic [RAND_W-1:0] LEFT_LIMIT = 31'd1997159792;

    localparam logic signed [COEF_W-1:0] XX_RESET    = 17'sd26869;
    localparam logic signed [COEF_W-1:0] XY_RESET    = 17'sd2621;
    localparam logic signed [COEF_W-1:0] YX_RESET    = -17'sd2621;
    localparam logic signed [OFF_W-1:0]  OFF_RESET   = 18'sd52428;
    localparam logic [SCALE_W-1:0]       SCALE_RESET = 21'd983040;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAIN_XX     = 3'd0,
        CFG_MAIN_XY     = 3'd1,
        CFG_MAIN_YX     = 3'd2,
        CFG_MAIN_OFFSET = 3'd3,
        CFG_SCREEN      = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MAP_STEM  = 2'd0,
        MAP_MAIN  = 2'd1,
        MAP_LEFT  = 2'd2,
        MAP_RIGHT = 2'd3
    } t_map;

    typedef enum logic [1:0] {
        MUL_MAP   = 2'd0,
        MUL_LEFT  = 2'd1,
        MUL_RIGHT = 2'd2,
        MUL_SCALE = 2'd3
    } t_mul_op;

    typedef struct packed {
        logic    load_sel;
        logic    mul_en;
        t_mul_op mul_op;
        logic    upd_point;
        logic    upd_left;
        logic    upd_right;
        logic    load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

>>> design/ifsf_if.sv
// ----------------------------------------------------------------------------
// ifsf_if
// Valid/ready channels of the fern point generator: the random number input
// and the point result output.
// ----------------------------------------------------------------------------
interface ifsf_in_if import ifsf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [RAND_W-1:0] random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface

interface ifsf_out_if import ifsf_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] point_x;
    logic signed [DATA_W-1:0] point_y;
    logic signed [DATA_W-1:0] left_x;
    logic signed [DATA_W-1:0] left_y;
    logic signed [DATA_W-1:0] right_x;
    logic signed [DATA_W-1:0] right_y;

    modport source (output valid, output point_x, output point_y, output left_x,
                    output left_y, output right_x, output right_y, input ready);
    modport sink   (input valid, input point_x, input point_y, input left_x,
                    input left_y, input right_x, input right_y, output ready);
endinterface

>>> design/ifs_fern_point_generator_top.sv
// An accepted beat passes the map, new point, left, right, right sum and scale
// states; its result is loaded into the output register in the done state, or later
// while the previous result still waits to be taken. The next beat is taken only
// after that load; the four shared multipliers serve the map, the two leaf maps and the scaling in turn.
// Reset clears the current point to zero and reloads the default coefficients.
// ----------------------------------------------------------------------------
// ifs_fern_point_generator_top
// Fern point generator: picks one of four affine maps per random beat, moves
// the stored point and emits it with its two scaled leaf images.
// ----------------------------------------------------------------------------
module ifs_fern_point_generator_top import ifsf_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ifsf_in_if.sink               i_in,
    ifsf_out_if.source            o_out
);

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;

    assign i_in.ready = w_in_ready;

    ifsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (w_status),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    ifsf_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_random_value (i_in.random_value),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_out          (o_out)
    );

    a_one_beat_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("Input accepted while a beat is still in work.");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> w_status.out_free)
        else $error("Output register overwritten before it was taken.");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |=> o_out.valid)
        else $error("Loaded result not presented as valid.");

endmodule

>>> design/ifsf_ctrl.sv
// ----------------------------------------------------------------------------
// ifsf_ctrl
// Sequencer of the fern point generator. Steps one beat through map
// products, new point, leaf products, leaf sums, scaling and output load.
// ----------------------------------------------------------------------------
module ifsf_ctrl import ifsf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_ctrl_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MAP   = 8'b0000_0010,
        S_NEW   = 8'b0000_0100,
        S_LEFT  = 8'b0000_1000,
        S_RIGHT = 8'b0001_0000,
        S_SUM_R = 8'b0010_0000,
        S_SCALE = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.mul_op = MUL_MAP;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_sel = 1'b1;
                    n_state        = S_MAP;
                end
            end
            S_MAP: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_MAP;
                n_state      = S_NEW;
            end
            S_NEW: begin
                o_cmd.upd_point = 1'b1;
                n_state         = S_LEFT;
            end
            S_LEFT: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_LEFT;
                n_state      = S_RIGHT;
            end
            S_RIGHT: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_op   = MUL_RIGHT;
                o_cmd.upd_left = 1'b1;
                n_state        = S_SUM_R;
            end
            S_SUM_R: begin
                o_cmd.upd_right = 1'b1;
                n_state         = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_SCALE;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> design/ifsf_datapath.sv
// ----------------------------------------------------------------------------
// ifsf_datapath
// Configuration registers, current point, four shared multipliers with
// floor scaling, the sum registers and the output register.
// ----------------------------------------------------------------------------
module ifsf_datapath import ifsf_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [RAND_W-1:0]     i_random_value,
    input  t_ctrl_cmd             i_cmd,
    output t_dp_status            o_status,
    ifsf_out_if.source            o_out
);

    localparam int B_W = (FRAC_BITS + 2 > SCALE_W + 1) ? FRAC_BITS + 2 : SCALE_W + 1;
    localparam int P_W = DATA_W + B_W;

    localparam longint ONE  = longint'(1) << FRAC_BITS;
    localparam longint Q15  = (15 * ONE) / 100;
    localparam longint Q16  = (16 * ONE) / 100;
    localparam longint Q20  = (20 * ONE) / 100;
    localparam longint Q22  = (22 * ONE) / 100;
    localparam longint Q23  = (23 * ONE) / 100;
    localparam longint Q24  = (24 * ONE) / 100;
    localparam longint Q26  = (26 * ONE) / 100;
    localparam longint Q28  = (28 * ONE) / 100;
    localparam longint Q44  = (44 * ONE) / 100;
    localparam longint Q85  = (85 * ONE) / 100;
    localparam longint Q160 = (160 * ONE) / 100;

    localparam logic signed [B_W-1:0] K16  = B_W'(Q16);
    localparam logic signed [B_W-1:0] K20  = B_W'(Q20);
    localparam logic signed [B_W-1:0] K22  = B_W'(Q22);
    localparam logic signed [B_W-1:0] K23  = B_W'(Q23);
    localparam logic signed [B_W-1:0] K24  = B_W'(Q24);
    localparam logic signed [B_W-1:0] K26  = B_W'(Q26);
    localparam logic signed [B_W-1:0] K28  = B_W'(Q28);
    localparam logic signed [B_W-1:0] K85  = B_W'(Q85);
    localparam logic signed [B_W-1:0] KN15 = B_W'(-Q15);

    localparam logic signed [DATA_W-1:0] C44  = DATA_W'(Q44);
    localparam logic signed [DATA_W-1:0] C160 = DATA_W'(Q160);

    logic signed [COEF_W-1:0]  r_xx;
    logic signed [COEF_W-1:0]  r_xy;
    logic signed [COEF_W-1:0]  r_yx;
    logic signed [OFF_W-1:0]   r_off;
    logic        [SCALE_W-1:0] r_scale;

    t_map                     r_sel;
    logic signed [DATA_W-1:0] r_x;
    logic signed [DATA_W-1:0] r_y;
    logic signed [DATA_W-1:0] r_lx;
    logic signed [DATA_W-1:0] r_ly;
    logic signed [DATA_W-1:0] r_rx;
    logic signed [DATA_W-1:0] r_ry;
    logic signed [DATA_W-1:0] r_p [4];
    logic                     r_out_valid;

    logic signed [DATA_W-1:0] w_a     [4];
    logic signed [B_W-1:0]    w_b     [4];
    logic signed [P_W-1:0]    w_prod  [4];
    logic signed [P_W-1:0]    w_shift [4];
    logic signed [B_W-1:0]    w_xx;
    logic signed [B_W-1:0]    w_xy;
    logic signed [B_W-1:0]    w_yx;
    logic signed [B_W-1:0]    w_sc;
    logic signed [DATA_W-1:0] w_k;
    t_map                     n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xx    <= XX_RESET;
            r_xy    <= XY_RESET;
            r_yx    <= YX_RESET;
            r_off   <= OFF_RESET;
            r_scale <= SCALE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAIN_XX:     r_xx    <= i_cfg_data[COEF_W-1:0];
                CFG_MAIN_XY:     r_xy    <= i_cfg_data[COEF_W-1:0];
                CFG_MAIN_YX:     r_yx    <= i_cfg_data[COEF_W-1:0];
                CFG_MAIN_OFFSET: r_off   <= i_cfg_data[OFF_W-1:0];
                CFG_SCREEN:      r_scale <= i_cfg_data[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        priority if (i_random_value < STEM_LIMIT) begin
            n_sel = MAP_STEM;
        end else if (i_random_value < MAIN_LIMIT) begin
            n_sel = MAP_MAIN;
        end else if (i_random_value < LEFT_LIMIT) begin
            n_sel = MAP_LEFT;
        end else begin
            n_sel = MAP_RIGHT;
        end
    end

    assign w_xx = {{(B_W-COEF_W){r_xx[COEF_W-1]}}, r_xx};
    assign w_xy = {{(B_W-COEF_W){r_xy[COEF_W-1]}}, r_xy};
    assign w_yx = {{(B_W-COEF_W){r_yx[COEF_W-1]}}, r_yx};
    assign w_sc = {{(B_W-SCALE_W){1'b0}}, r_scale};

    always_comb begin
        w_a[0] = r_x;
        w_a[1] = r_y;
        w_a[2] = r_x;
        w_a[3] = r_y;
        w_b[0] = K20;
        w_b[1] = K26;
        w_b[2] = K23;
        w_b[3] = K22;
        unique case (i_cmd.mul_op)
            MUL_MAP: begin
                unique case (r_sel)
                    MAP_STEM: begin
                        w_b[0] = '0;
                        w_b[1] = '0;
                        w_b[2] = '0;
                        w_b[3] = K16;
                    end
                    MAP_MAIN: begin
                        w_b[0] = w_xx;
                        w_b[1] = w_xy;
                        w_b[2] = w_yx;
                        w_b[3] = K85;
                    end
                    MAP_LEFT: begin
                        w_b[0] = K20;
                        w_b[1] = K26;
                        w_b[2] = K23;
                        w_b[3] = K22;
                    end
                    MAP_RIGHT: begin
                        w_b[0] = KN15;
                        w_b[1] = K28;
                        w_b[2] = K26;
                        w_b[3] = K24;
                    end
                    default: begin
                    end
                endcase
            end
            MUL_LEFT: begin
            end
            MUL_RIGHT: begin
                w_b[0] = KN15;
                w_b[1] = K28;
                w_b[2] = K26;
                w_b[3] = K24;
            end
            MUL_SCALE: begin
                w_a[0] = r_lx;
                w_a[1] = r_ly;
                w_a[2] = r_rx;
                w_a[3] = r_ry;
                w_b[0] = w_sc;
                w_b[1] = w_sc;
                w_b[2] = w_sc;
                w_b[3] = w_sc;
            end
            default: begin
            end
        endcase
    end

    for (genvar g = 0; g < 4; g++) begin : g_mul
        assign w_prod[g]  = w_a[g] * w_b[g];
        assign w_shift[g] = w_prod[g] >>> FRAC_BITS;
    end

    always_comb begin
        unique case (r_sel)
            MAP_STEM:  w_k = '0;
            MAP_MAIN:  w_k = {{(DATA_W-OFF_W){r_off[OFF_W-1]}}, r_off};
            MAP_LEFT:  w_k = C160;
            MAP_RIGHT: w_k = C44;
            default:   w_k = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
        end else if (i_cmd.upd_point) begin
            r_x <= (r_sel == MAP_LEFT) ? r_p[0] - r_p[1] : r_p[0] + r_p[1];
            r_y <= r_p[2] + r_p[3] + w_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sel) begin
            r_sel <= n_sel;
        end
        if (i_cmd.mul_en) begin
            for (int i = 0; i < 4; i++) begin
                r_p[i] <= w_shift[i][DATA_W-1:0];
            end
        end
        if (i_cmd.upd_left) begin
            r_lx <= r_p[0] - r_p[1];
            r_ly <= r_p[2] + r_p[3] + C160;
        end
        if (i_cmd.upd_right) begin
            r_rx <= r_p[0] + r_p[1];
            r_ry <= r_p[2] + r_p[3] + C44;
        end
        if (i_cmd.load_out) begin
            o_out.point_x <= r_x;
            o_out.point_y <= r_y;
            o_out.left_x  <= r_p[0];
            o_out.left_y  <= r_p[1];
            o_out.right_x <= r_p[2];
            o_out.right_y <= r_p[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_status.out_free = !r_out_valid || o_out.ready;

endmodule

>>> dv/ifs_fern_point_generator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifs_fern_point_generator_top_tb
// Drives random-number beats into the fern point generator and predicts each
// point and its two scaled leaf images. Random stalls on both channels are
// used, and the run steps through default, extreme and random coefficient
// settings. Every result beat is compared field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module ifs_fern_point_generator_top_tb import ifsf_pkg::*; ();

    localparam int FRAC_BITS     = FRAC_BITS_DEF;
    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int MAX_IDLE      = 4;
    localparam int SETTLE_CYCLES = 12;
    localparam int N_FIELDS      = 6;
    localparam int TIMEOUT_NS    = 3_000_000;

    localparam longint ONE_Q       = longint'(1) << FRAC_BITS;
    localparam longint K_STEM_YY   = (16 * ONE_Q) / 100;
    localparam longint K_MAIN_YY   = (85 * ONE_Q) / 100;
    localparam longint K_LEFT_XX   = (20 * ONE_Q) / 100;
    localparam longint K_LEFT_XY   = (26 * ONE_Q) / 100;
    localparam longint K_LEFT_YX   = (23 * ONE_Q) / 100;
    localparam longint K_LEFT_YY   = (22 * ONE_Q) / 100;
    localparam longint K_LEFT_OFF  = (160 * ONE_Q) / 100;
    localparam longint K_RIGHT_XX  = -((15 * ONE_Q) / 100);
    localparam longint K_RIGHT_XY  = (28 * ONE_Q) / 100;
    localparam longint K_RIGHT_YX  = (26 * ONE_Q) / 100;
    localparam longint K_RIGHT_YY  = (24 * ONE_Q) / 100;
    localparam longint K_RIGHT_OFF = (44 * ONE_Q) / 100;

    localparam logic [RAND_W-1:0]  RAND_ALL  = '1;
    localparam logic [COEF_W-1:0]  COEF_MAX  = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0]  COEF_MIN  = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic [OFF_W-1:0]   OFF_MAX   = {1'b0, {(OFF_W-1){1'b1}}};
    localparam logic [OFF_W-1:0]   OFF_MIN   = {1'b1, {(OFF_W-1){1'b0}}};
    localparam logic [SCALE_W-1:0] SCALE_MAX = '1;

    typedef logic [N_FIELDS-1:0][DATA_W-1:0] t_fern_beat;

    class fern_scoreboard;
        logic signed [COEF_W-1:0] main_xx;
        logic signed [COEF_W-1:0] main_xy;
        logic signed [COEF_W-1:0] main_yx;
        logic signed [OFF_W-1:0]  main_offset;
        logic [SCALE_W-1:0]       scale;
        logic [DATA_W-1:0]        cur_x;
        logic [DATA_W-1:0]        cur_y;
        t_fern_beat               expected_points[$];
        int                       failures;
        string                    field_names[N_FIELDS];

        function new();
            main_xx     = XX_RESET;
            main_xy     = XY_RESET;
            main_yx     = YX_RESET;
            main_offset = OFF_RESET;
            scale       = SCALE_RESET;
            cur_x       = '0;
            cur_y       = '0;
            failures    = 0;
            field_names = '{"point_x", "point_y", "left_x", "left_y", "right_x", "right_y"};
        endfunction

        function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MAIN_XX:     main_xx = data[COEF_W-1:0];
                CFG_MAIN_XY:     main_xy = data[COEF_W-1:0];
                CFG_MAIN_YX:     main_yx = data[COEF_W-1:0];
                CFG_MAIN_OFFSET: main_offset = data[OFF_W-1:0];
                CFG_SCREEN:      scale = data[SCALE_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [DATA_W-1:0] qmul(longint a, longint b);
            longint p;
            p = (a * b) >>> FRAC_BITS;
            return p[DATA_W-1:0];
        endfunction

        function longint wide(logic [DATA_W-1:0] v);
            return longint'($signed(v));
        endfunction

        function logic [DATA_W-1:0] left_x_of(longint x, longint y);
            return qmul(K_LEFT_XX, x) - qmul(K_LEFT_XY, y);
        endfunction

        function logic [DATA_W-1:0] left_y_of(longint x, longint y);
            return qmul(K_LEFT_YX, x) + qmul(K_LEFT_YY, y) + DATA_W'(K_LEFT_OFF);
        endfunction

        function logic [DATA_W-1:0] right_x_of(longint x, longint y);
            return qmul(K_RIGHT_XX, x) + qmul(K_RIGHT_XY, y);
        endfunction

        function logic [DATA_W-1:0] right_y_of(longint x, longint y);
            return qmul(K_RIGHT_YX, x) + qmul(K_RIGHT_YY, y) + DATA_W'(K_RIGHT_OFF);
        endfunction

        function t_map map_of(logic [RAND_W-1:0] r);
            if (r < STEM_LIMIT) begin
                return MAP_STEM;
            end else if (r < MAIN_LIMIT) begin
                return MAP_MAIN;
            end else if (r < LEFT_LIMIT) begin
                return MAP_LEFT;
            end
            return MAP_RIGHT;
        endfunction

        function void note_random(logic [RAND_W-1:0] r);
            longint     x;
            longint     y;
            longint     a;
            longint     b;
            longint     gain;
            t_fern_beat want;
            x = wide(cur_x);
            y = wide(cur_y);
            case (map_of(r))
                MAP_STEM: begin
                    cur_x = '0;
                    cur_y = qmul(K_STEM_YY, y);
                end
                MAP_MAIN: begin
                    cur_x = qmul(longint'(main_xx), x) + qmul(longint'(main_xy), y);
                    cur_y = qmul(longint'(main_yx), x) + qmul(K_MAIN_YY, y)
                            + DATA_W'(longint'(main_offset));
                end
                MAP_LEFT: begin
                    cur_x = left_x_of(x, y);
                    cur_y = left_y_of(x, y);
                end
                default: begin
                    cur_x = right_x_of(x, y);
                    cur_y = right_y_of(x, y);
                end
            endcase
            a = wide(cur_x);
            b = wide(cur_y);
            gain = longint'(scale);
            want[0] = cur_x;
            want[1] = cur_y;
            want[2] = qmul(gain, wide(left_x_of(a, b)));
            want[3] = qmul(gain, wide(left_y_of(a, b)));
            want[4] = qmul(gain, wide(right_x_of(a, b)));
            want[5] = qmul(gain, wide(right_y_of(a, b)));
            expected_points.push_back(want);
        endfunction

        function void check_point(t_fern_beat got);
            t_fern_beat want;
            if (expected_points.size() == 0) begin
                $display("%0t: result beat with none expected, expected none, actual point_x %0d",
                         $time, $signed(got[0]));
                failures++;
                return;
            end
            want = expected_points.pop_front();
            for (int i = 0; i < N_FIELDS; i++) begin
                if (got[i] !== want[i]) begin
                    $display("%0t: %s mismatch, expected %0d, actual %0d", $time,
                             field_names[i], $signed(want[i]), $signed(got[i]));
                    failures++;
                end
            end
        endfunction

        function int pending();
            return expected_points.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    bit                    idle_on;
    fern_scoreboard        sb;

    ifsf_in_if  in_if ();
    ifsf_out_if out_if ();

    ifs_fern_point_generator_top #(
        .FRAC_BITS (FRAC_BITS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic logic [RAND_W-1:0] draw_random();
        logic [RAND_W-1:0] border;
        case ($urandom_range(0, 9))
            0: return RAND_W'($urandom_range(0, STEM_LIMIT - 1));
            1: return RAND_W'($urandom_range(MAIN_LIMIT, LEFT_LIMIT - 1));
            2: return RAND_W'($urandom_range(LEFT_LIMIT, RAND_ALL));
            3: begin
                case ($urandom_range(0, 2))
                    0: border = STEM_LIMIT;
                    1: border = MAIN_LIMIT;
                    default: border = LEFT_LIMIT;
                endcase
                return RAND_W'(border - 2 + $urandom_range(0, 3));
            end
            default: return RAND_W'($urandom());
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.configure(idx, data);
    endtask

    task automatic write_unused_regs();
        for (int k = CFG_SCREEN + 1; k < (1 << CFG_IDX_W); k++) begin
            write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom()));
        end
    endtask

    task automatic send_random(input logic [RAND_W-1:0] value);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.random_value <= value;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sb.note_random(value);
    endtask

    task automatic send_batch(input int count);
        repeat (count) send_random(draw_random());
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : result_sink
        int         gap;
        t_fern_beat got;
        out_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (out_if.valid !== 1'b1);
            got = {out_if.right_y, out_if.right_x, out_if.left_y, out_if.left_x,
                   out_if.point_y, out_if.point_x};
            sb.check_point(got);
        end
    end

    initial begin : stimulus
        sb      = new();
        idle_on = 1'b1;
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_index        <= '0;
        i_cfg_data         <= '0;
        in_if.valid        <= 1'b0;
        in_if.random_value <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Map boundaries on both sides of every threshold, at reset coefficients.
        send_random('0);
        send_random(STEM_LIMIT - 1);
        send_random(STEM_LIMIT);
        send_random(MAIN_LIMIT - 1);
        send_random(MAIN_LIMIT);
        send_random(LEFT_LIMIT - 1);
        send_random(LEFT_LIMIT);
        send_random(RAND_ALL);
        repeat (4) send_random(MAIN_LIMIT - 1);
        send_random(STEM_LIMIT);
        send_random(LEFT_LIMIT);
        send_random(RAND_ALL);
        send_random('0);
        send_batch(120);
        settle();

        // Extreme coefficients with junk above the coefficient and offset widths; the main
        // map then grows until the point wraps.
        idle_on = 1'b0;
        write_reg(CFG_MAIN_XX, {{(CFG_DATA_W-COEF_W){1'b1}}, COEF_MAX});
        write_reg(CFG_MAIN_XY, {{(CFG_DATA_W-COEF_W){1'b1}}, COEF_MAX});
        write_reg(CFG_MAIN_YX, {{(CFG_DATA_W-COEF_W){1'b1}}, COEF_MIN});
        write_reg(CFG_MAIN_OFFSET, {{(CFG_DATA_W-OFF_W){1'b1}}, OFF_MAX});
        write_reg(CFG_SCREEN, SCALE_MAX);
        write_unused_regs();
        repeat (8) send_random(MAIN_LIMIT - 1);
        send_batch(100);
        settle();

        idle_on = 1'b1;
        write_reg(CFG_MAIN_XX, CFG_DATA_W'(COEF_MIN));
        write_reg(CFG_MAIN_XY, CFG_DATA_W'(COEF_MIN));
        write_reg(CFG_MAIN_YX, CFG_DATA_W'(COEF_MAX));
        write_reg(CFG_MAIN_OFFSET, CFG_DATA_W'(OFF_MIN));
        write_reg(CFG_SCREEN, '0);
        send_batch(80);
        settle();

        for (int p = 0; p < 4; p++) begin
            idle_on = (p != 2);
            for (int k = CFG_MAIN_XX; k <= CFG_SCREEN; k++) begin
                write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom()));
            end
            write_unused_regs();
            send_batch(70);
            settle();
        end

        write_reg(CFG_MAIN_XX, CFG_DATA_W'(XX_RESET));
        write_reg(CFG_MAIN_XY, CFG_DATA_W'(XY_RESET));
        write_reg(CFG_MAIN_YX, CFG_DATA_W'(YX_RESET));
        write_reg(CFG_MAIN_OFFSET, CFG_DATA_W'(OFF_RESET));
        write_reg(CFG_SCREEN, CFG_DATA_W'(SCALE_RESET));
        send_batch(40);
        settle();

        if (sb.failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

endmodule
